[rtl/art_pkg.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Route table package
// Shared types and codes for the aging route table and its cell chain.
// ----------------------------------------------------------------------------
package art_pkg;

   // Widths of the fixed port fields.
   localparam int ID_PORT_W = 16;
   localparam int LIFE_W    = 8;
   localparam int CMD_W     = 3;
   localparam int STATUS_W  = 2;

   // Command codes.
   localparam logic [CMD_W-1:0] CMD_INSERT = 3'd0;
   localparam logic [CMD_W-1:0] CMD_REMOVE = 3'd1;
   localparam logic [CMD_W-1:0] CMD_LOOKUP = 3'd2;
   localparam logic [CMD_W-1:0] CMD_TICK   = 3'd3;
   localparam logic [CMD_W-1:0] CMD_CLEAR  = 3'd4;

   // Status codes.
   localparam logic [STATUS_W-1:0] ST_DONE    = 2'd0;
   localparam logic [STATUS_W-1:0] ST_REFRESH = 2'd1;
   localparam logic [STATUS_W-1:0] ST_FULL    = 2'd2;
   localparam logic [STATUS_W-1:0] ST_MISS    = 2'd3;

   typedef struct packed {
      logic [CMD_W-1:0]     command;
      logic [ID_PORT_W-1:0] dest_id;
      logic [ID_PORT_W-1:0] hop_id;
   } req_type;

   typedef struct packed {
      logic [STATUS_W-1:0]  status;
      logic                 found;
      logic [ID_PORT_W-1:0] route_hop;
      logic [ID_PORT_W-1:0] oldest_hop;
      logic                 not_empty;
   } rsp_type;

   // Control broadcast from the sequencer to every cell.
   typedef struct packed {
      logic [CMD_W-1:0]  cmd;
      logic              compact;
      logic [LIFE_W-1:0] lifetime;
   } cell_ctl_type;

   // Token that walks down the chain, one cell per cycle.
   typedef struct packed {
      logic active;
      logic hit;
      logic placed;
   } tok_type;

endpackage

[rtl/aging_route_table_top.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Aging route table
// Insertion-ordered route table with aging, built as a chain of slot cells.
// ----------------------------------------------------------------------------
//
//   Channel   Ports                         Direction  Beat taken when
//   --------  ----------------------------  ---------  -----------------------
//   request   start, busy, req_data         in         start high, busy low
//   response  rsp_valid, rsp_data           out        rsp_valid high (1 cycle)
//   config    csr_we, csr_wdata             in         csr_we high
//
// Every request beat produces exactly one response beat. A command walks a
// token down the cell chain, one cell per cycle. Remove and tick then run a
// compaction pass in which entries slide toward slot 0 to close gaps. busy
// drops in the cycle the response is shown, so a new request can be taken
// right alongside it. The reset is synchronous and empties the table; the
// lifetime register returns to five. The receiver cannot stall the response.
// ----------------------------------------------------------------------------
module aging_route_table_top #(
   parameter int TABLE_DEPTH = 16,
   parameter int ID_WIDTH    = 16
) (
   input  logic                         clock,
   input  logic                         reset,
   input  logic                         start,
   output logic                         busy,
   input  art_pkg::req_type             req_data,
   output logic                         rsp_valid,
   output art_pkg::rsp_type             rsp_data,
   input  logic                         csr_we,
   input  logic [art_pkg::LIFE_W-1:0]   csr_wdata
);
   import art_pkg::*;

   // Ids arrive on 16-bit fields; a narrower id width keeps only its low bits.
   localparam int KeyW = (ID_WIDTH < ID_PORT_W) ? ID_WIDTH : ID_PORT_W;
   localparam int CntW = $clog2(TABLE_DEPTH);

   typedef enum logic [1:0] {
      S_IDLE,
      S_WALK,
      S_COMPACT,
      S_REPLY
   } state_type;

   state_type         state_ff;
   logic              busy_ff;
   logic              launch_ff;
   logic [CMD_W-1:0]  cmd_ff;
   logic [KeyW-1:0]   dest_ff;
   logic [KeyW-1:0]   hop_ff;
   logic [CntW-1:0]   cnt_ff;
   logic              hit_ff;
   logic              placed_ff;
   logic [KeyW-1:0]   route_ff;
   logic              rsp_valid_ff;
   rsp_type           rsp_data_ff;
   logic [LIFE_W-1:0] lifetime_ff;

   cell_ctl_type      cell_ctl;
   tok_type           tok_head;

   tok_type           tok_chain   [TABLE_DEPTH];
   logic [KeyW-1:0]   route_chain [TABLE_DEPTH];
   logic              cell_valid  [TABLE_DEPTH];
   logic [KeyW-1:0]   cell_dest   [TABLE_DEPTH];
   logic [KeyW-1:0]   cell_hop    [TABLE_DEPTH];
   logic [LIFE_W-1:0] cell_age    [TABLE_DEPTH];

   tok_type           tok_tail;
   logic [KeyW-1:0]   route_tail;

   // The lifetime register is to be written only while the table is idle, so
   // the cells can read it directly during a command; the block does not enforce it.
   always_ff @(posedge clock) begin
      if (reset) begin
         lifetime_ff <= LIFE_W'(5);
      end else if (csr_we) begin
         lifetime_ff <= csr_wdata;
      end
   end

   assign cell_ctl.cmd      = cmd_ff;
   assign cell_ctl.compact  = (state_ff == S_COMPACT);
   assign cell_ctl.lifetime = lifetime_ff;

   assign tok_head.active = launch_ff;
   assign tok_head.hit    = 1'b0;
   assign tok_head.placed = 1'b0;

   for (genvar i = 0; i < TABLE_DEPTH; i++) begin : g_cell
      tok_type           tok_prev;
      logic [KeyW-1:0]   route_prev;
      logic              left_valid;
      logic              right_valid;
      logic [KeyW-1:0]   right_dest;
      logic [KeyW-1:0]   right_hop;
      logic [LIFE_W-1:0] right_age;

      if (i == 0) begin : g_head
         // The head has no left neighbor and never hands its entry over.
         assign tok_prev   = tok_head;
         assign route_prev = '0;
         assign left_valid = 1'b1;
      end else begin : g_body
         assign tok_prev   = tok_chain[i-1];
         assign route_prev = route_chain[i-1];
         assign left_valid = cell_valid[i-1];
      end

      if (i == TABLE_DEPTH - 1) begin : g_tail
         assign right_valid = 1'b0;
         assign right_dest  = '0;
         assign right_hop   = '0;
         assign right_age   = '0;
      end else begin : g_next
         assign right_valid = cell_valid[i+1];
         assign right_dest  = cell_dest[i+1];
         assign right_hop   = cell_hop[i+1];
         assign right_age   = cell_age[i+1];
      end

      art_cell #(
         .KEY_W (KeyW)
      ) u_cell (
         .clock       (clock),
         .reset       (reset),
         .ctl         (cell_ctl),
         .key_dest    (dest_ff),
         .key_hop     (hop_ff),
         .tok_prev    (tok_prev),
         .route_prev  (route_prev),
         .tok_out     (tok_chain[i]),
         .route_out   (route_chain[i]),
         .left_valid  (left_valid),
         .right_valid (right_valid),
         .right_dest  (right_dest),
         .right_hop   (right_hop),
         .right_age   (right_age),
         .valid       (cell_valid[i]),
         .dest        (cell_dest[i]),
         .hop         (cell_hop[i]),
         .age         (cell_age[i])
      );
   end

   assign tok_tail   = tok_chain[TABLE_DEPTH-1];
   assign route_tail = route_chain[TABLE_DEPTH-1];

   // Sequencer: take a request, launch the token, collect the outcome at the
   // tail, compact after a remove or tick, then show the response. The
   // response reads slot 0 after all updates have settled.
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         busy_ff      <= 1'b0;
         launch_ff    <= 1'b0;
         cnt_ff       <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         launch_ff    <= 1'b0;
         rsp_valid_ff <= 1'b0;
         case (state_ff)
            S_IDLE: begin
               if (start) begin
                  cmd_ff    <= req_data.command;
                  dest_ff   <= req_data.dest_id[KeyW-1:0];
                  hop_ff    <= req_data.hop_id[KeyW-1:0];
                  launch_ff <= 1'b1;
                  busy_ff   <= 1'b1;
                  state_ff  <= S_WALK;
               end
            end
            S_WALK: begin
               if (tok_tail.active) begin
                  hit_ff    <= tok_tail.hit;
                  placed_ff <= tok_tail.placed;
                  route_ff  <= route_tail;
                  cnt_ff    <= '0;
                  if (cmd_ff == CMD_REMOVE || cmd_ff == CMD_TICK) begin
                     state_ff <= S_COMPACT;
                  end else begin
                     state_ff <= S_REPLY;
                  end
               end
            end
            S_COMPACT: begin
               // Each gap moves one slot per cycle, and the pass always
               // packs the chain.
               cnt_ff <= cnt_ff + CntW'(1);
               if (cnt_ff == CntW'(TABLE_DEPTH - 1)) begin
                  state_ff <= S_REPLY;
               end
            end
            S_REPLY: begin
               rsp_valid_ff          <= 1'b1;
               rsp_data_ff.status    <= ST_DONE;
               rsp_data_ff.found     <= 1'b0;
               rsp_data_ff.route_hop <= '0;
               case (cmd_ff)
                  CMD_INSERT: begin
                     if (hit_ff) begin
                        rsp_data_ff.status <= ST_REFRESH;
                     end else if (!placed_ff) begin
                        rsp_data_ff.status <= ST_FULL;
                     end
                  end
                  CMD_REMOVE: begin
                     if (!hit_ff) begin
                        rsp_data_ff.status <= ST_MISS;
                     end
                  end
                  CMD_LOOKUP: begin
                     if (hit_ff) begin
                        rsp_data_ff.found     <= 1'b1;
                        rsp_data_ff.route_hop <= ID_PORT_W'(route_ff);
                     end else begin
                        rsp_data_ff.status <= ST_MISS;
                     end
                  end
                  default: begin
                  end
               endcase
               rsp_data_ff.oldest_hop <= cell_valid[0] ? ID_PORT_W'(cell_hop[0]) : '0;
               rsp_data_ff.not_empty  <= cell_valid[0];
               busy_ff  <= 1'b0;
               state_ff <= S_IDLE;
            end
            default: begin
               state_ff <= S_IDLE;
               busy_ff  <= 1'b0;
            end
         endcase
      end
   end

   assign busy      = busy_ff;
   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_data_ff;

endmodule

[rtl/art_cell.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Route table cell
// One table slot. Applies the command when the token passes and moves its
// entry toward the head while the chain is being compacted.
// ----------------------------------------------------------------------------
module art_cell #(
   parameter int KEY_W = 16
) (
   input  logic                        clock,
   input  logic                        reset,
   input  art_pkg::cell_ctl_type       ctl,
   input  logic [KEY_W-1:0]            key_dest,
   input  logic [KEY_W-1:0]            key_hop,
   input  art_pkg::tok_type            tok_prev,
   input  logic [KEY_W-1:0]            route_prev,
   output art_pkg::tok_type            tok_out,
   output logic [KEY_W-1:0]            route_out,
   input  logic                        left_valid,
   input  logic                        right_valid,
   input  logic [KEY_W-1:0]            right_dest,
   input  logic [KEY_W-1:0]            right_hop,
   input  logic [art_pkg::LIFE_W-1:0]  right_age,
   output logic                        valid,
   output logic [KEY_W-1:0]            dest,
   output logic [KEY_W-1:0]            hop,
   output logic [art_pkg::LIFE_W-1:0]  age
);
   import art_pkg::*;

   logic              valid_ff, valid_in;
   logic [KEY_W-1:0]  dest_ff, dest_in;
   logic [KEY_W-1:0]  hop_ff, hop_in;
   logic [LIFE_W-1:0] age_ff, age_in;
   tok_type           tok_ff, tok_in;
   logic [KEY_W-1:0]  route_ff, route_in;

   always_comb begin
      valid_in = valid_ff;
      dest_in  = dest_ff;
      hop_in   = hop_ff;
      age_in   = age_ff;
      tok_in   = tok_prev;
      route_in = route_prev;
      if (ctl.compact) begin
         // An empty slot pulls its right neighbor in; a full slot with an
         // empty left neighbor hands its entry over.
         if (!valid_ff) begin
            valid_in = right_valid;
            dest_in  = right_dest;
            hop_in   = right_hop;
            age_in   = right_age;
         end else if (!left_valid) begin
            valid_in = 1'b0;
         end
      end else if (tok_prev.active) begin
         case (ctl.cmd)
            CMD_INSERT: begin
               if (valid_ff && hop_ff == key_hop && !tok_prev.hit) begin
                  age_in     = ctl.lifetime;
                  tok_in.hit = 1'b1;
               end else if (!valid_ff && !tok_prev.hit && !tok_prev.placed) begin
                  valid_in      = 1'b1;
                  dest_in       = key_dest;
                  hop_in        = key_hop;
                  age_in        = ctl.lifetime;
                  tok_in.placed = 1'b1;
               end
            end
            CMD_REMOVE: begin
               if (valid_ff && hop_ff == key_hop && !tok_prev.hit) begin
                  valid_in   = 1'b0;
                  tok_in.hit = 1'b1;
               end
            end
            CMD_LOOKUP: begin
               if (valid_ff && dest_ff == key_dest && !tok_prev.hit) begin
                  tok_in.hit = 1'b1;
                  route_in   = hop_ff;
               end
            end
            CMD_TICK: begin
               if (valid_ff) begin
                  if (age_ff == '0) begin
                     valid_in = 1'b0;
                  end else begin
                     age_in = age_ff - LIFE_W'(1);
                  end
               end
            end
            CMD_CLEAR: begin
               valid_in = 1'b0;
            end
            default: begin
            end
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
         tok_ff   <= '0;
      end else begin
         valid_ff <= valid_in;
         tok_ff   <= tok_in;
      end
   end

   always_ff @(posedge clock) begin
      dest_ff  <= dest_in;
      hop_ff   <= hop_in;
      age_ff   <= age_in;
      route_ff <= route_in;
   end

   assign tok_out   = tok_ff;
   assign route_out = route_ff;
   assign valid     = valid_ff;
   assign dest      = dest_ff;
   assign hop       = hop_ff;
   assign age       = age_ff;

endmodule

[test/testbench.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Aging route table testbench
// Sends route commands through the start/busy handshake and checks every
// response beat against a shadow copy of the table kept inside the bench.
// A directed part covers the empty table, refresh, full-table drops and
// aging. Four random phases follow, each setting the entry lifetime and the
// sender idling anew.
// ----------------------------------------------------------------------------
module testbench;
   import art_pkg::*;

   localparam int TABLE_DEPTH       = 16;
   localparam int ID_WIDTH          = 16;
   localparam int CLK_PERIOD        = 10;
   localparam int SLOW_LATENCY      = 2 * TABLE_DEPTH + 3;
   localparam int CYCLE_LIMIT       = 200000;
   localparam int MAX_REPORTS       = 10;
   localparam int NODE_POOL_SIZE    = 24;
   localparam logic [LIFE_W-1:0] LIFETIME_AT_RESET = 8'd5;
   // Command codes that the block treats as no-ops.
   localparam logic [CMD_W-1:0] CMD_SPARE_FIRST = 3'd5;
   localparam logic [CMD_W-1:0] CMD_SPARE_LAST  = 3'd7;

   // Every input has a known value from time zero on.
   logic              clock     = 1'b0;
   logic              reset     = 1'b1;
   logic              start     = 1'b0;
   logic              busy;
   req_type           req_data  = '0;
   logic              rsp_valid;
   rsp_type           rsp_data;
   logic              csr_we    = 1'b0;
   logic [LIFE_W-1:0] csr_wdata = '0;

   // Shadow copy of the table. Live entries are packed from slot 0 upward
   // in insertion order, exactly as the block keeps them.
   logic [ID_PORT_W-1:0] shadow_dest [TABLE_DEPTH];
   logic [ID_PORT_W-1:0] shadow_hop  [TABLE_DEPTH];
   logic [LIFE_W-1:0]    shadow_age  [TABLE_DEPTH];
   int                   shadow_count;
   logic [LIFE_W-1:0]    shadow_lifetime;

   // Responses that have been predicted but not yet seen, oldest first.
   rsp_type pending_routes[$];

   // Node ids that the random traffic draws from, so that hits are common.
   logic [ID_PORT_W-1:0] node_pool [NODE_POOL_SIZE];

   int idle_pct;
   int beats_sent;
   int beats_checked;
   int error_count;
   int cycle_count;
   int status_seen [4];

   aging_route_table_top #(
      .TABLE_DEPTH (TABLE_DEPTH),
      .ID_WIDTH    (ID_WIDTH)
   ) u_dut (
      .clock     (clock),
      .reset     (reset),
      .start     (start),
      .busy      (busy),
      .req_data  (req_data),
      .rsp_valid (rsp_valid),
      .rsp_data  (rsp_data),
      .csr_we    (csr_we),
      .csr_wdata (csr_wdata)
   );

   always #(CLK_PERIOD / 2) clock = ~clock;

   // -------------------------------------------------------------------------
   // Shadow table
   // -------------------------------------------------------------------------

   // Index of the first live entry with this next hop, or -1.
   function automatic int find_hop(input logic [ID_PORT_W-1:0] hop);
      for (int i = 0; i < shadow_count; i++) begin
         if (shadow_hop[i] == hop) return i;
      end
      return -1;
   endfunction

   // Removes one entry and slides the younger ones down to close the gap.
   function automatic void drop_slot(input int slot);
      for (int i = slot; i + 1 < shadow_count; i++) begin
         shadow_dest[i] = shadow_dest[i + 1];
         shadow_hop[i]  = shadow_hop[i + 1];
         shadow_age[i]  = shadow_age[i + 1];
      end
      shadow_count--;
   endfunction

   // Applies one command to the shadow table and returns the response the
   // block must give for it.
   function automatic rsp_type predict_route_result(input req_type beat);
      rsp_type res;
      int      idx;
      res        = '0;
      res.status = ST_DONE;
      case (beat.command)
         CMD_INSERT: begin
            idx = find_hop(beat.hop_id);
            if (idx >= 0) begin
               // Known next hop: only its age is reloaded, the destination
               // stays as first learned.
               shadow_age[idx] = shadow_lifetime;
               res.status      = ST_REFRESH;
            end else if (shadow_count >= TABLE_DEPTH) begin
               res.status = ST_FULL;
            end else begin
               shadow_dest[shadow_count] = beat.dest_id;
               shadow_hop[shadow_count]  = beat.hop_id;
               shadow_age[shadow_count]  = shadow_lifetime;
               shadow_count++;
            end
         end
         CMD_REMOVE: begin
            idx = find_hop(beat.hop_id);
            if (idx >= 0) drop_slot(idx);
            else res.status = ST_MISS;
         end
         CMD_LOOKUP: begin
            res.status = ST_MISS;
            for (int i = 0; i < shadow_count; i++) begin
               if (shadow_dest[i] == beat.dest_id) begin
                  res.status    = ST_DONE;
                  res.found     = 1'b1;
                  res.route_hop = shadow_hop[i];
                  break;
               end
            end
         end
         CMD_TICK: begin
            // Entries already at age zero expire; all others count down.
            idx = 0;
            while (idx < shadow_count) begin
               if (shadow_age[idx] == '0) begin
                  drop_slot(idx);
               end else begin
                  shadow_age[idx] = shadow_age[idx] - 1'b1;
                  idx++;
               end
            end
         end
         CMD_CLEAR: shadow_count = 0;
         default: ;
      endcase
      res.not_empty  = (shadow_count > 0);
      res.oldest_hop = (shadow_count > 0) ? shadow_hop[0] : '0;
      return res;
   endfunction

   // -------------------------------------------------------------------------
   // Request side
   // -------------------------------------------------------------------------

   function automatic req_type route_beat(input logic [CMD_W-1:0] command,
                                          input logic [ID_PORT_W-1:0] dest,
                                          input logic [ID_PORT_W-1:0] hop);
      req_type beat;
      beat.command = command;
      beat.dest_id = dest;
      beat.hop_id  = hop;
      return beat;
   endfunction

   // Presents one command and waits until the block takes it. The prediction
   // is made at the accepting edge, so the queue follows acceptance order.
   // When the sender goes idle, the gap can run past a full remove or tick,
   // which moves the next start across every stage of the block's work.
   // With no gap, start simply stays high for the next beat.
   task automatic send_route_cmd(input req_type beat);
      int gap;
      start    <= 1'b1;
      req_data <= beat;
      do @(posedge clock); while (busy !== 1'b0);
      pending_routes.push_back(predict_route_result(beat));
      beats_sent++;
      gap = 0;
      if ($urandom_range(99) < idle_pct) gap = $urandom_range(SLOW_LATENCY + 5, 1);
      if (gap > 0) begin
         start <= 1'b0;
         repeat (gap) @(posedge clock);
      end
   endtask

   // Drops start and waits until every predicted response has come back.
   // Each command yields exactly one response, and busy falls with it, so
   // the block is idle once the queue is empty.
   task automatic drain_routes();
      start <= 1'b0;
      while (pending_routes.size() != 0) @(posedge clock);
   endtask

   // Lifetime writes happen only while the block is idle.
   task automatic write_lifetime(input logic [LIFE_W-1:0] lifetime);
      drain_routes();
      csr_we    <= 1'b1;
      csr_wdata <= lifetime;
      @(posedge clock);
      shadow_lifetime = lifetime;
      csr_we <= 1'b0;
   endtask

   // Mostly ids from the pool, now and then any 16-bit value.
   function automatic logic [ID_PORT_W-1:0] pick_node_id();
      if ($urandom_range(99) < 85) return node_pool[$urandom_range(NODE_POOL_SIZE - 1)];
      return ID_PORT_W'($urandom);
   endfunction

   function automatic req_type random_route_cmd();
      req_type beat;
      int      roll;
      beat.dest_id = pick_node_id();
      beat.hop_id  = pick_node_id();
      roll         = $urandom_range(99);
      if (roll < 38)      beat.command = CMD_INSERT;
      else if (roll < 52) beat.command = CMD_REMOVE;
      else if (roll < 74) beat.command = CMD_LOOKUP;
      else if (roll < 90) beat.command = CMD_TICK;
      else if (roll < 93) beat.command = CMD_CLEAR;
      else beat.command = CMD_W'($urandom_range(CMD_SPARE_LAST, CMD_SPARE_FIRST));
      return beat;
   endfunction

   // -------------------------------------------------------------------------
   // Response checking
   // -------------------------------------------------------------------------

   // Outputs are sampled at the rising edge, before the block's own updates
   // for that edge land, so each response is seen in the cycle it is shown.
   always @(posedge clock) begin : check_routes
      rsp_type want;
      if (!reset && rsp_valid === 1'b1) begin
         if (pending_routes.size() == 0) begin
            error_count++;
            if (error_count <= MAX_REPORTS)
               $display("[%0t] response beat with nothing expected: st=%0d hop=%h",
                        $time, rsp_data.status, rsp_data.oldest_hop);
         end else begin
            want = pending_routes.pop_front();
            beats_checked++;
            status_seen[want.status]++;
            if (rsp_data.status     !== want.status    ||
                rsp_data.found      !== want.found     ||
                rsp_data.route_hop  !== want.route_hop ||
                rsp_data.oldest_hop !== want.oldest_hop ||
                rsp_data.not_empty  !== want.not_empty) begin
               error_count++;
               if (error_count <= MAX_REPORTS) begin
                  $display("[%0t] response %0d mismatch", $time, beats_checked);
                  $display("   expected st=%0d found=%0d route=%h oldest=%h not_empty=%0d",
                           want.status, want.found, want.route_hop,
                           want.oldest_hop, want.not_empty);
                  $display("   actual   st=%0d found=%0d route=%h oldest=%h not_empty=%0d",
                           rsp_data.status, rsp_data.found, rsp_data.route_hop,
                           rsp_data.oldest_hop, rsp_data.not_empty);
               end
            end
         end
      end
   end

   // -------------------------------------------------------------------------
   // Tests
   // -------------------------------------------------------------------------

   // Commands on an empty table: misses, a tick with nothing to age, and
   // the unused codes, which must leave everything as it is.
   task automatic test_empty_table();
      send_route_cmd(route_beat(CMD_LOOKUP, 16'h0000, 16'hFFFF));
      send_route_cmd(route_beat(CMD_REMOVE, 16'hFFFF, 16'hFFFF));
      send_route_cmd(route_beat(CMD_TICK, 16'hFFFF, 16'h0000));
      send_route_cmd(route_beat(CMD_SPARE_FIRST, ID_PORT_W'($urandom), ID_PORT_W'($urandom)));
      send_route_cmd(route_beat(CMD_SPARE_LAST, 16'hFFFF, 16'hFFFF));
   endtask

   // A second insert of a known next hop refreshes it and keeps the old
   // destination, so a lookup of the new destination must miss. A removed
   // entry that is inserted again goes to the tail.
   task automatic test_refresh_and_lookup();
      send_route_cmd(route_beat(CMD_INSERT, 16'h0000, 16'h0000));
      send_route_cmd(route_beat(CMD_INSERT, 16'hFFFF, 16'hFFFF));
      send_route_cmd(route_beat(CMD_INSERT, 16'h1234, 16'h0000));
      send_route_cmd(route_beat(CMD_LOOKUP, 16'h1234, 16'h0000));
      send_route_cmd(route_beat(CMD_LOOKUP, 16'hFFFF, 16'h0000));
      send_route_cmd(route_beat(CMD_REMOVE, 16'h0000, 16'h0000));
      send_route_cmd(route_beat(CMD_INSERT, 16'h0000, 16'h0000));
   endtask

   // Fill every slot, then a new hop must be dropped while a known hop is
   // still refreshed. The last lookup hits the entry in the last slot.
   task automatic test_full_table();
      for (int k = 0; k < TABLE_DEPTH - 2; k++)
         send_route_cmd(route_beat(CMD_INSERT, ID_PORT_W'(16'h8000 | k),
                                   ID_PORT_W'(16'h0100 + k)));
      send_route_cmd(route_beat(CMD_INSERT, 16'h4321, 16'h0200));
      send_route_cmd(route_beat(CMD_INSERT, 16'h5555, 16'hFFFF));
      send_route_cmd(route_beat(CMD_LOOKUP, 16'h800D, 16'h0000));
   endtask

   // With a lifetime of zero a refreshed entry in mid-table expires at the
   // next tick while its neighbors only age, and the gap is closed. A fresh
   // tail entry with age zero goes the same way.
   task automatic test_aging();
      write_lifetime(8'd0);
      send_route_cmd(route_beat(CMD_INSERT, 16'h0000, 16'h0105));
      send_route_cmd(route_beat(CMD_TICK, 16'h0000, 16'h0000));
      send_route_cmd(route_beat(CMD_LOOKUP, 16'h8005, 16'h0000));
      send_route_cmd(route_beat(CMD_INSERT, 16'h0777, 16'h0777));
      send_route_cmd(route_beat(CMD_TICK, 16'h0000, 16'h0000));
      send_route_cmd(route_beat(CMD_CLEAR, 16'hFFFF, 16'hFFFF));
   endtask

   // One random phase: a fresh id pool, a lifetime written while idle, and
   // the sender idling as asked.
   task automatic run_random_phase(input int beats, input int pct,
                                   input logic [LIFE_W-1:0] lifetime);
      write_lifetime(lifetime);
      idle_pct = pct;
      for (int i = 0; i < NODE_POOL_SIZE; i++) node_pool[i] = ID_PORT_W'($urandom);
      for (int i = 0; i < beats; i++) send_route_cmd(random_route_cmd());
   endtask

   // Random traffic under four settings: longest lifetime without idling,
   // zero lifetime with a mostly idle sender, then short and arbitrary
   // lifetimes with moderate and heavy idling.
   task automatic test_random_traffic();
      run_random_phase(104, 0, 8'd255);
      run_random_phase(104, 61, 8'd0);
      run_random_phase(104, 37, LIFE_W'($urandom_range(8, 1)));
      run_random_phase(104, 61, LIFE_W'($urandom_range(255)));
   endtask

   // -------------------------------------------------------------------------
   // Sequence
   // -------------------------------------------------------------------------

   initial begin
      idle_pct        = 0;
      beats_sent      = 0;
      beats_checked   = 0;
      error_count     = 0;
      shadow_count    = 0;
      shadow_lifetime = LIFETIME_AT_RESET;
      for (int i = 0; i < 4; i++) status_seen[i] = 0;
      repeat (2) @(posedge clock);
      reset <= 1'b0;

      // The directed part runs on the lifetime left by reset until the aging test writes zero.
      test_empty_table();
      test_refresh_and_lookup();
      test_full_table();
      test_aging();
      test_random_traffic();

      // Let any stray response beat show up before the verdict.
      drain_routes();
      repeat (SLOW_LATENCY + 8) @(posedge clock);
      error_count += pending_routes.size();

      $display("Ran %0d commands and checked %0d responses over lifetimes 5, 0, 255 and random.",
               beats_sent, beats_checked);
      $display("Status counts: done %0d, refreshed %0d, full %0d, not found %0d.",
               status_seen[ST_DONE], status_seen[ST_REFRESH],
               status_seen[ST_FULL], status_seen[ST_MISS]);
      if (error_count == 0) begin
         $display("ALL CHECKS PASSED");
      end else begin
         $display("CHECKS FAILED");
      end
      $finish;
   end

   // Watchdog: a run that hangs on the handshake ends here.
   initial begin
      cycle_count = 0;
      while (cycle_count < CYCLE_LIMIT) begin
         @(posedge clock);
         cycle_count++;
      end
      $display("Timed out after %0d cycles with %0d responses outstanding.",
               cycle_count, pending_routes.size());
      $display("CHECKS FAILED");
      $finish;
   end

endmodule
